[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rank quota role assigner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RQRA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: %m");

// The expression must never be true outside reset.
`define RQRA_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition: %m");

`endif

[rtl/rqra_pkg.sv]
// ----------------------------------------------------------------------------
// rqra_pkg
// Types and constants shared by the rank quota role assigner modules.
// ----------------------------------------------------------------------------
package rqra_pkg;

  localparam int MaxAgents = 64;
  localparam int IdxW      = $clog2(MaxAgents);
  localparam int CountW    = IdxW + 1;
  localparam int EnergyW   = 16;
  localparam int RoleW     = 3;

  // Reciprocal of ten scaled by 2^11; exact floor for counts up to 64.
  localparam int Recip10   = 205;
  localparam int Recip10Sh = 11;

  localparam logic [RoleW-1:0] RoleWorker   = 3'd0;
  localparam logic [RoleW-1:0] RoleLeader   = 3'd1;
  localparam logic [RoleW-1:0] RoleScout    = 3'd2;
  localparam logic [RoleW-1:0] RoleGuardian = 3'd3;
  localparam logic [RoleW-1:0] RoleRelay    = 3'd4;

  // Controls from the sequencer to the rank unit.
  typedef struct packed {
    logic load_base;  // capture the energy of the agent being ranked
    logic cmp_en;     // count one comparison against the energy on the read port
  } ctl_t;

endpackage

[rtl/rqra_ram.sv]
// ----------------------------------------------------------------------------
// rqra_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rqra_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/rqra_rank_unit.sv]
// ----------------------------------------------------------------------------
// rqra_rank_unit
// Shared comparator that counts how many agents outrank the base agent.
// ----------------------------------------------------------------------------
module rqra_rank_unit (
  input  logic                           clk,
  input  rqra_pkg::ctl_t                 ctl,
  input  logic [rqra_pkg::EnergyW-1:0]   rd_data,
  input  logic [rqra_pkg::IdxW-1:0]      base_idx,
  input  logic [rqra_pkg::IdxW-1:0]      cmp_idx,
  output logic [rqra_pkg::IdxW-1:0]      rank
);
  import rqra_pkg::*;

  logic [EnergyW-1:0] base_energy;
  logic               beats;

  // An equal energy loaded earlier ranks higher.
  assign beats = (rd_data > base_energy) ||
                 ((rd_data == base_energy) && (cmp_idx < base_idx));

  always_ff @(posedge clk) begin
    if (ctl.load_base) begin
      base_energy <= rd_data;
      rank        <= '0;
    end else if (ctl.cmp_en && beats) begin
      rank <= rank + 1'b1;
    end
  end

endmodule

[rtl/rank_quota_role_assigner_top.sv]
// ----------------------------------------------------------------------------
// rank_quota_role_assigner_top
// Loads agent energies, ranks them with one shared comparator and emits one
// role per agent in load order by rank quota.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  in       | in_valid / in_ready    | energy, final_agent
//  out      | out_valid / out_ready  | agent_index, role, end_of_run
//
// A request is accepted whenever the sequencer is loading. After the final
// request the n agents are ranked one at a time, each result waiting on out_ready;
// the single comparator reads one stored energy per cycle from the RAM port.
// Reset clears the sequencer and agent count; the energy RAM needs no clear.
// in_ready is low from the final request until the last result is taken.
`include "assert_macros.svh"

module rank_quota_role_assigner_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rqra_pkg::EnergyW-1:0]     energy,
  input  logic                             final_agent,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rqra_pkg::IdxW-1:0]        agent_index,
  output logic [rqra_pkg::RoleW-1:0]       role,
  output logic                             end_of_run
);
  import rqra_pkg::*;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StFetch = 3'd1;
  localparam logic [2:0] StBase  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StRole  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0]          state;
  logic [CountW-1:0]   count;
  logic [IdxW-1:0]     cur;        // agent being ranked
  logic [IdxW-1:0]     scan;       // agent whose energy is on the read port
  logic [IdxW-1:0]     last_idx;
  logic [CountW-1:0]   lim1, lim2, lim3, lim4;
  logic [IdxW-1:0]     rank;
  logic [EnergyW-1:0]  rd_data;
  logic [IdxW-1:0]     rd_addr;
  ctl_t                ctl;

  logic                in_acc;
  logic                store_en;
  logic [CountW-1:0]   n_fin;
  logic [CountW+7:0]   prod;
  logic [CountW-1:0]   div10, div5, lead;
  logic [RoleW-1:0]    role_next;

  assign in_ready = (state == StLoad);
  assign in_acc   = in_valid && in_ready;
  assign store_en = in_acc && (count < CountW'(MaxAgents));
  assign n_fin    = store_en ? count + 1'b1 : count;

  // Quotas for the run size: n/10 and n/5 by reciprocal multiply.
  assign prod  = n_fin * (CountW+8)'(Recip10);
  assign div10 = CountW'(prod >> Recip10Sh);
  assign div5  = CountW'(prod >> (Recip10Sh - 1));
  assign lead  = (div10 == '0) ? CountW'(1) : div10;

  always_comb begin
    case (state)
      StFetch: rd_addr = cur;
      StScan:  rd_addr = scan + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  assign ctl.load_base = (state == StBase);
  assign ctl.cmp_en    = (state == StScan);

  always_comb begin
    if (CountW'(rank) < lim1) begin
      role_next = RoleLeader;
    end else if (CountW'(rank) < lim2) begin
      role_next = RoleScout;
    end else if (CountW'(rank) < lim3) begin
      role_next = RoleGuardian;
    end else if (CountW'(rank) < lim4) begin
      role_next = RoleRelay;
    end else begin
      role_next = RoleWorker;
    end
  end

  rqra_ram #(
    .Width (EnergyW),
    .Depth (MaxAgents)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (count[IdxW-1:0]),
    .wr_data (energy),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rqra_rank_unit u_rank (
    .clk      (clk),
    .ctl      (ctl),
    .rd_data  (rd_data),
    .base_idx (cur),
    .cmp_idx  (scan),
    .rank     (rank)
  );

  // Sequencer and agent count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StLoad;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        StLoad: begin
          if (store_en) begin
            count <= count + 1'b1;
          end
          if (in_acc && final_agent) begin
            state <= StFetch;
          end
        end
        StFetch: state <= StBase;
        StBase:  state <= StScan;
        StScan: begin
          if (scan == last_idx) begin
            state <= StRole;
          end
        end
        StRole: begin
          out_valid <= 1'b1;
          state     <= StEmit;
        end
        StEmit: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cur == last_idx) begin
              count <= '0;
              state <= StLoad;
            end else begin
              state <= StFetch;
            end
          end
        end
        default: state <= StLoad;
      endcase
    end
  end

  // Indices, quotas and result payload.
  always_ff @(posedge clk) begin
    if (in_acc && final_agent) begin
      cur      <= '0;
      last_idx <= IdxW'(n_fin - 1'b1);
      lim1     <= lead;
      lim2     <= lead + div5;
      lim3     <= lead + div5 + div10;
      lim4     <= lead + div5 + div10 + div10;
    end
    if (state == StBase) begin
      scan <= '0;
    end else if (state == StScan) begin
      scan <= scan + 1'b1;
    end
    if (state == StRole) begin
      agent_index <= cur;
      role        <= role_next;
      end_of_run  <= (cur == last_idx);
    end
    if ((state == StEmit) && out_ready && (cur != last_idx)) begin
      cur <= cur + 1'b1;
    end
  end

  `RQRA_NEVER(a_no_load_while_emitting, clk, rst, in_ready && out_valid)
  `RQRA_ASSERT(a_rank_in_range, clk, rst, (state == StRole) |-> (rank <= last_idx))
  `RQRA_ASSERT(a_end_marks_last, clk, rst,
      (out_valid && end_of_run) |-> (agent_index == last_idx))
  `RQRA_ASSERT(a_valid_only_in_emit, clk, rst, out_valid |-> (state == StEmit))

endmodule

[test/tb_rank_quota_role_assigner_top.sv]
// ----------------------------------------------------------------------------
// tb_rank_quota_role_assigner_top
// Drives runs of agent energies into the role assigner and checks every role
// against an in-bench ranking and quota calculation, or against the role given
// in the table for typed directed rows. A short directed table runs first, then
// random runs of mixed sizes, including one that overflows the agent store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rank_quota_role_assigner_top;
  import rqra_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [RoleW-1:0] role;
    logic             eor;
  } role_result_t;

  typedef struct packed {
    logic [EnergyW-1:0] e;
    logic               fin;
    logic               typed;
    logic [RoleW-1:0]   role;
  } row_t;

  localparam int NumRows = 17;

  // Rows with typed = 1 carry a role that is obvious by inspection; the rest
  // are checked against the predictor.
  localparam row_t DirectedRows [NumRows] = '{
    // single agent at both energy extremes
    '{16'h0000, 1'b1, 1'b1, RoleLeader},
    '{16'hffff, 1'b1, 1'b1, RoleLeader},
    // tie of two: the earlier load wins
    '{16'h8000, 1'b0, 1'b1, RoleLeader},
    '{16'h8000, 1'b1, 1'b1, RoleWorker},
    // three agents with a tie at the top
    '{16'h0000, 1'b0, 1'b1, RoleWorker},
    '{16'hffff, 1'b0, 1'b1, RoleLeader},
    '{16'hffff, 1'b1, 1'b1, RoleWorker},
    // ten agents reach every role
    '{16'd100,   1'b0, 1'b0, RoleWorker},
    '{16'd900,   1'b0, 1'b0, RoleWorker},
    '{16'd300,   1'b0, 1'b0, RoleWorker},
    '{16'h0000,  1'b0, 1'b0, RoleWorker},
    '{16'hffff,  1'b0, 1'b0, RoleWorker},
    '{16'd500,   1'b0, 1'b0, RoleWorker},
    '{16'd500,   1'b0, 1'b0, RoleWorker},
    '{16'd700,   1'b0, 1'b0, RoleWorker},
    '{16'd1,     1'b0, 1'b0, RoleWorker},
    '{16'd200,   1'b1, 1'b0, RoleWorker}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [EnergyW-1:0] energy = '0;
  logic               final_agent = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IdxW-1:0]    agent_index;
  logic [RoleW-1:0]   role;
  logic               end_of_run;

  // Typed expectation that travels with the request on the input side.
  logic               req_typed = 1'b0;
  logic [RoleW-1:0]   req_role = RoleWorker;

  // Set during a stretch where neither side idles.
  bit steady = 1'b0;

  role_result_t       pending_roles[$];
  logic [EnergyW-1:0] held_energy [MaxAgents];
  logic               typed_seen [MaxAgents];
  logic [RoleW-1:0]   typed_roles [MaxAgents];
  int                 held_count = 0;
  int                 mismatches = 0;

  rank_quota_role_assigner_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .energy      (energy),
    .final_agent (final_agent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .agent_index (agent_index),
    .role        (role),
    .end_of_run  (end_of_run)
  );

  always #5 clk = ~clk;

  function automatic logic [RoleW-1:0] quota_role(int rank, int n);
    int lim;
    lim = (n / 10 < 1) ? 1 : n / 10;
    if (rank < lim) return RoleLeader;
    lim += n / 5;
    if (rank < lim) return RoleScout;
    lim += n / 10;
    if (rank < lim) return RoleGuardian;
    lim += n / 10;
    if (rank < lim) return RoleRelay;
    return RoleWorker;
  endfunction

  // Stores the energy if there is room; a final mark ranks the whole run.
  task automatic take_request(logic [EnergyW-1:0] e, logic fin, logic tv,
                              logic [RoleW-1:0] tr);
    int rank;
    role_result_t r;
    if (held_count < MaxAgents) begin
      held_energy[held_count] = e;
      typed_seen[held_count]  = tv;
      typed_roles[held_count] = tr;
      held_count++;
    end
    if (fin) begin
      for (int i = 0; i < held_count; i++) begin
        rank = 0;
        for (int j = 0; j < held_count; j++) begin
          if (held_energy[j] > held_energy[i] ||
              (held_energy[j] == held_energy[i] && j < i)) begin
            rank++;
          end
        end
        r.idx  = i[IdxW-1:0];
        r.role = typed_seen[i] ? typed_roles[i] : quota_role(rank, held_count);
        r.eor  = (i == held_count - 1);
        pending_roles.insert(pending_roles.size(), r);
      end
      held_count = 0;
    end
  endtask

  task automatic check_result();
    role_result_t want;
    if (pending_roles.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected result: index %0d role %0d end %0b",
                 agent_index, role, end_of_run);
      end
      mismatches++;
    end else begin
      want = pending_roles.pop_front();
      if (agent_index !== want.idx || role !== want.role || end_of_run !== want.eor) begin
        if (mismatches < 10) begin
          $display("mismatch at %0t: expected index %0d role %0d end %0b, got %0d %0d %0b",
                   $realtime, want.idx, want.role, want.eor, agent_index, role, end_of_run);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_request(energy, final_agent, req_typed, req_role);
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && (steady || $urandom_range(0, 99) >= 31);
  end

  task automatic send_request(logic [EnergyW-1:0] e, logic fin, logic tv,
                              logic [RoleW-1:0] tr);
    if (!steady) begin
      while ($urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    energy      <= e;
    final_agent <= fin;
    req_typed   <= tv;
    req_role    <= tr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Some runs draw from a few values so that ties are common.
  function automatic logic [EnergyW-1:0] pick_energy(int mode);
    if (mode == 0) return 16'($urandom_range(0, 65535));
    if (mode == 2) return 16'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      default: return 16'h7fff;
    endcase
  endfunction

  initial begin
    int total;
    int run_no;
    int run_len;
    int mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < NumRows; k++) begin
      send_request(DirectedRows[k].e, DirectedRows[k].fin, DirectedRows[k].typed,
                   DirectedRows[k].role);
    end

    // Run one overflows the store; runs three and four go without idling.
    total  = NumRows;
    run_no = 0;
    while (total < 180) begin
      if (run_no == 1) run_len = 70;
      else if (run_no == 3) run_len = 64;
      else if ($urandom_range(0, 5) == 0) run_len = $urandom_range(13, 40);
      else run_len = $urandom_range(1, 12);
      mode   = $urandom_range(0, 2);
      steady = (run_no == 3 || run_no == 4);
      for (int k = 0; k < run_len; k++) begin
        send_request(pick_energy(mode), k == run_len - 1, 1'b0, RoleWorker);
      end
      total += run_len;
      if (run_no == 2) begin
        // Hold off until the whole run has drained.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_roles.size() != 0) @(posedge clk);
      end
      run_no++;
    end
    steady   = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_roles.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_roles.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
